/* src/sdc_pkg.sv */
// Package: shared types and constants of the slot drift compensator.
package sdc_pkg;

   typedef enum logic [1:0] {
      CMD_SYNC  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_MULTI = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_NONE   = 2'd0,
      DIR_FASTER = 2'd1,
      DIR_SLOWER = 2'd2
   } dir_type;

   localparam logic [1:0] CSR_SLOT_DURATION = 2'd0;
   localparam logic [1:0] CSR_LARGE_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_ADJUST        = 2'd2;

   localparam logic [15:0] RST_SLOT_DURATION = 16'd491;
   localparam logic [14:0] RST_LARGE_LIMIT   = 15'd8;
   localparam logic [7:0]  RST_ADJUST        = 8'd1;

   localparam int DVD_W = 48;
   localparam int DSR_W = 17;
   localparam logic [5:0] DIV_STEPS_SYNC = 6'd48;
   localparam logic [5:0] DIV_STEPS_TICK = 6'd16;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] time_correction;
      logic               sync_by_ack;
      logic [63:0]        source_address;
      logic               is_synced;
      logic [39:0]        slot_number;
      logic [15:0]        slot_count;
   } req_type;

   typedef struct packed {
      logic        period_update;
      logic [31:0] slot_period;
      logic [1:0]  clock_direction;
      logic [15:0] interval_slots;
   } rsp_type;

   typedef struct packed {
      logic [15:0] slot_duration;
      logic [14:0] large_limit;
      logic [7:0]  adjust;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] corr;
      logic [15:0] mag;
      logic        pos;
      logic        ack;
      logic [63:0] src;
      logic        synced;
      logic [39:0] slot;
      logic [15:0] n;
      logic [16:0] mult;
   } item_type;

   typedef struct packed {
      logic             start;
      logic [5:0]       steps;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DSR_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* src/slot_drift_compensator.sv */
// Slot drift compensator: top level with configuration registers.
//
// Requests enter on req_valid/req_data; req_stall is high while the request
// queue is full. Each request yields exactly one result on rsp_valid/rsp_data,
// in request order. A result is held in an output register until the receiver
// drops rsp_stall; meanwhile new requests keep filling the queue.
// Configuration writes use csr_valid/csr_ready with csr_index/csr_wdata;
// csr_ready is always high. Write only while no request is outstanding.
// Paths from transfer to result:
//   slot tick without expiry, unknown direction, small sync, mismatch: no divide
//   slot tick with expiry: 16-step divide for the expiry count
//   large sync: 48-step divide for the interval
// One request is executed at a time; the shared divider produces one
// quotient bit per cycle.
// Synchronous reset clears the queue, the drift state and the output register
// and loads the configuration reset values.
module slot_drift_compensator #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   sdc_pkg::cfg_type      cfg_ff, cfg_in;
   sdc_pkg::item_type     new_item;
   sdc_pkg::item_type     head;
   sdc_pkg::div_req_type  div_req;
   sdc_pkg::div_rsp_type  div_rsp;
   logic                  push;
   logic                  pop;
   logic                  empty;
   logic                  full;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign push      = req_valid && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sdc_pkg::CSR_SLOT_DURATION: cfg_in.slot_duration = csr_wdata;
            sdc_pkg::CSR_LARGE_LIMIT:   cfg_in.large_limit   = csr_wdata[14:0];
            sdc_pkg::CSR_ADJUST:        cfg_in.adjust        = csr_wdata[7:0];
            default:                    cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_duration <= sdc_pkg::RST_SLOT_DURATION;
         cfg_ff.large_limit   <= sdc_pkg::RST_LARGE_LIMIT;
         cfg_ff.adjust        <= sdc_pkg::RST_ADJUST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdc_front u_front (
      .req_data (req_data),
      .item     (new_item)
   );

   sdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (new_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   sdc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/sdc_front.sv */
// Front end: decodes an accepted request into a queue item.
module sdc_front (
   input  sdc_pkg::req_type  req_data,
   output sdc_pkg::item_type item
);

   logic [15:0] raw;

   assign raw = req_data.time_correction;

   always_comb begin
      item.cmd    = sdc_pkg::cmd_type'(req_data.command);
      item.corr   = raw;
      item.mag    = raw[15] ? (~raw + 16'd1) : raw;
      item.pos    = !raw[15] && (raw != 16'd0);
      item.ack    = req_data.sync_by_ack;
      item.src    = req_data.source_address;
      item.synced = req_data.is_synced;
      item.slot   = req_data.slot_number;
      unique case (item.cmd)
         sdc_pkg::CMD_TICK: begin
            item.n    = 16'd1;
            item.mult = 17'd1;
         end
         sdc_pkg::CMD_MULTI: begin
            item.n    = req_data.slot_count;
            item.mult = {1'b0, req_data.slot_count} + 17'd1;
         end
         default: begin
            item.n    = 16'd0;
            item.mult = 17'd0;
         end
      endcase
   end

endmodule

/* src/sdc_queue.sv */
// Short FIFO between the front end and the execution back end.
module sdc_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sdc_pkg::item_type push_item,
   input  logic              pop,
   output sdc_pkg::item_type head,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sdc_pkg::item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/sdc_div.sv */
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
module sdc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sdc_pkg::div_req_type req,
   output sdc_pkg::div_rsp_type rsp
);

   logic [sdc_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [sdc_pkg::DSR_W-1:0] dsr_ff, dsr_in;
   logic [sdc_pkg::DSR_W-1:0] rem_ff, rem_in;
   logic [5:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [sdc_pkg::DSR_W:0]   rem_sh;
   logic [sdc_pkg::DSR_W:0]   rem_sub;
   logic                      ge;

   assign rem_sh  = {rem_ff, dvd_ff[sdc_pkg::DVD_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[sdc_pkg::DVD_W-2:0], ge};
         rem_in = ge ? rem_sub[sdc_pkg::DSR_W-1:0] : rem_sh[sdc_pkg::DSR_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

/* src/sdc_back.sv */
// Back end: drift state, sequencer over the divider, and result register.
module sdc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sdc_pkg::cfg_type      cfg,
   input  sdc_pkg::item_type     head,
   input  logic                  empty,
   output logic                  pop,
   output sdc_pkg::div_req_type  div_req,
   input  sdc_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sdc_pkg::rsp_type      rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_POST = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type         st_ff, st_in;
   sdc_pkg::dir_type  dir_ff, dir_in;
   logic [63:0]       last_src_ff, last_src_in;
   logic [39:0]       last_slot_ff, last_slot_in;
   logic [15:0]       interval_ff, interval_in;
   logic [15:0]       countdown_ff, countdown_in;
   logic [15:0]       applied_ff, applied_in;
   logic [15:0]       corr_sum_ff, corr_sum_in;
   logic              tick_mode_ff, tick_mode_in;
   logic [16:0]       per_ff, per_in;
   logic [32:0]       base_ff, base_in;
   logic [16:0]       qexp_ff, qexp_in;
   logic [24:0]       delta_ff, delta_in;
   logic              upd_ff, upd_in;
   logic [31:0]       period_ff, period_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sdc_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic        match;
   logic        big_corr;
   logic [39:0] elapsed;
   logic [47:0] num;
   logic [16:0] den;
   logic [16:0] first;
   logic [16:0] per;
   logic        short_run;
   logic [15:0] nrem;
   logic [32:0] base;
   logic [33:0] sum;

   assign match     = head.synced && (head.src == last_src_ff);
   assign big_corr  = head.mag > {1'b0, cfg.large_limit};
   assign elapsed   = head.slot - last_slot_ff;
   assign num       = 48'(cfg.adjust) * 48'(elapsed);
   assign den       = {1'b0, head.mag} + {1'b0, corr_sum_ff};
   assign first     = (countdown_ff == 16'd0) ? 17'h10000 : {1'b0, countdown_ff};
   assign per       = (interval_ff == 16'd0) ? 17'h10000 : {1'b0, interval_ff};
   assign short_run = {1'b0, head.n} < first;
   assign nrem      = head.n - first[15:0];
   assign base      = 33'(cfg.slot_duration) * 33'(head.mult);
   assign sum       = {1'b0, base_ff} + 34'(delta_ff);

   always_comb begin
      st_in        = st_ff;
      dir_in       = dir_ff;
      last_src_in  = last_src_ff;
      last_slot_in = last_slot_ff;
      interval_in  = interval_ff;
      countdown_in = countdown_ff;
      applied_in   = applied_ff;
      corr_sum_in  = corr_sum_ff;
      tick_mode_in = tick_mode_ff;
      per_in       = per_ff;
      base_in      = base_ff;
      qexp_in      = qexp_ff;
      delta_in     = delta_ff;
      upd_in       = upd_ff;
      period_in    = period_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      div_req      = '0;

      unique case (st_ff)
         ST_IDLE: begin
            if (!empty) begin
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pop       = 1'b1;
            upd_in    = 1'b0;
            period_in = 32'd0;
            st_in     = ST_DONE;
            unique case (head.cmd)
               sdc_pkg::CMD_SYNC: begin
                  if (!match) begin
                     dir_in       = sdc_pkg::DIR_NONE;
                     interval_in  = 16'd0;
                     countdown_in = 16'd0;
                     applied_in   = 16'd0;
                     corr_sum_in  = 16'd0;
                     last_src_in  = head.src;
                     last_slot_in = head.slot;
                  end else if (big_corr) begin
                     applied_in = 16'd0;
                     if (dir_ff == sdc_pkg::DIR_NONE) begin
                        dir_in = (head.pos != head.ack) ? sdc_pkg::DIR_FASTER
                                                        : sdc_pkg::DIR_SLOWER;
                     end
                     div_req.start    = 1'b1;
                     div_req.steps    = sdc_pkg::DIV_STEPS_SYNC;
                     div_req.dividend = num;
                     div_req.divisor  = den;
                     corr_sum_in      = 16'd0;
                     last_src_in      = head.src;
                     last_slot_in     = head.slot;
                     tick_mode_in     = 1'b0;
                     st_in            = ST_DIV;
                  end else begin
                     applied_in  = 16'd0;
                     corr_sum_in = corr_sum_ff + head.corr;
                  end
               end
               sdc_pkg::CMD_TICK, sdc_pkg::CMD_MULTI: begin
                  if (dir_ff == sdc_pkg::DIR_NONE) begin
                     st_in = ST_DONE;
                  end else if (short_run) begin
                     countdown_in = countdown_ff - head.n;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.steps    = sdc_pkg::DIV_STEPS_TICK;
                     div_req.dividend = {nrem, 32'd0};
                     div_req.divisor  = per;
                     per_in           = per;
                     base_in          = base;
                     tick_mode_in     = 1'b1;
                     st_in            = ST_DIV;
                  end
               end
               default: begin
                  st_in = ST_DONE;
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (tick_mode_ff) begin
                  qexp_in      = {1'b0, div_rsp.quotient[15:0]} + 17'd1;
                  countdown_in = 16'(per_ff - div_rsp.remainder);
                  st_in        = ST_POST;
               end else begin
                  interval_in  = (|div_rsp.quotient[47:16]) ? 16'hFFFF
                                                            : div_rsp.quotient[15:0];
                  countdown_in = interval_in;
                  st_in        = ST_DONE;
               end
            end
         end
         ST_POST: begin
            delta_in = 25'(qexp_ff) * 25'(cfg.adjust);
            st_in    = ST_FIN;
         end
         ST_FIN: begin
            if (dir_ff == sdc_pkg::DIR_FASTER) begin
               period_in = (|sum[33:32]) ? 32'hFFFF_FFFF : sum[31:0];
            end else begin
               period_in = (base_ff > 33'(delta_ff)) ? 32'(base_ff - 33'(delta_ff)) : 32'd0;
            end
            applied_in = applied_ff + delta_ff[15:0];
            upd_in     = 1'b1;
            st_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.period_update   = upd_ff;
               rsp_data_in.slot_period     = period_ff;
               rsp_data_in.clock_direction = dir_ff;
               rsp_data_in.interval_slots  = interval_ff;
               st_in                       = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         dir_ff       <= sdc_pkg::DIR_NONE;
         last_src_ff  <= '0;
         last_slot_ff <= '0;
         interval_ff  <= '0;
         countdown_ff <= '0;
         applied_ff   <= '0;
         corr_sum_ff  <= '0;
         tick_mode_ff <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         dir_ff       <= dir_in;
         last_src_ff  <= last_src_in;
         last_slot_ff <= last_slot_in;
         interval_ff  <= interval_in;
         countdown_ff <= countdown_in;
         applied_ff   <= applied_in;
         corr_sum_ff  <= corr_sum_in;
         tick_mode_ff <= tick_mode_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      per_ff      <= per_in;
      base_ff     <= base_in;
      qexp_ff     <= qexp_in;
      delta_ff    <= delta_in;
      period_ff   <= period_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/sdc_checker.sv */
// Port-level checker for the slot drift compensator, bound to the top level.
module sdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sdc_pkg::rsp_type rsp_data
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   a_no_update_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.period_update |-> rsp_data.slot_period == 32'd0)
      else $error("period reported without update");

   a_update_needs_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.clock_direction == sdc_pkg::DIR_NONE)
         |-> !rsp_data.period_update)
      else $error("period update with unknown drift direction");

endmodule

bind slot_drift_compensator sdc_checker u_sdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* verif/sdc_drift_checker.sv */
// Checker: predicts slot drift compensator results and compares each result transfer.
module sdc_drift_checker
   import sdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   logic [15:0] slot_ticks;
   logic [14:0] corr_limit;
   logic [7:0]  adjust;
   dir_type     drift;
   logic [63:0] time_source;
   logic [39:0] sync_slot;
   logic [15:0] interval;
   logic [15:0] countdown;
   logic [15:0] applied;
   logic [15:0] corr_sum;
   rsp_type     expected_results[$];
   int          errs = 0;

   task automatic report_mismatch(input string msg);
      if (errs < 200) begin
         $display("%0t: %s", $time, msg);
      end
      errs++;
   endtask

   function automatic void clear_drift();
      drift       = DIR_NONE;
      time_source = '0;
      sync_slot   = '0;
      interval    = '0;
      countdown   = '0;
      applied     = '0;
      corr_sum    = '0;
   endfunction

   function automatic rsp_type compensate(input req_type r);
      rsp_type     res;
      int          corr;
      int          mag;
      logic [39:0] elapsed;
      logic [63:0] quot;
      logic [63:0] first;
      logic [63:0] per;
      logic [63:0] n;
      logic [63:0] mult;
      logic [63:0] expiries;
      logic [63:0] base;
      logic [63:0] delta;
      logic [63:0] period;
      res  = '0;
      corr = r.time_correction;
      mag  = (corr < 0) ? -corr : corr;
      case (r.command)
         CMD_SYNC: begin
            if (r.is_synced && r.source_address == time_source) begin
               applied = '0;
               if (mag > int'(corr_limit)) begin
                  elapsed = r.slot_number - sync_slot;
                  if (drift == DIR_NONE) begin
                     drift = ((corr > 0) != r.sync_by_ack) ? DIR_FASTER : DIR_SLOWER;
                  end
                  quot = (64'(adjust) * 64'(elapsed)) / (64'(mag) + 64'(corr_sum));
                  interval    = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
                  countdown   = interval;
                  corr_sum    = '0;
                  sync_slot   = r.slot_number;
                  time_source = r.source_address;
               end else begin
                  corr_sum = corr_sum + r.time_correction;
               end
            end else begin
               clear_drift();
               sync_slot   = r.slot_number;
               time_source = r.source_address;
            end
         end
         CMD_TICK, CMD_MULTI: begin
            if (drift != DIR_NONE) begin
               n     = (r.command == CMD_TICK) ? 64'd1 : 64'(r.slot_count);
               mult  = (r.command == CMD_TICK) ? 64'd1 : n + 64'd1;
               first = (countdown == 0) ? 64'd65536 : 64'(countdown);
               per   = (interval == 0) ? 64'd65536 : 64'(interval);
               if (n < first) begin
                  countdown = countdown - n[15:0];
               end else begin
                  expiries  = 64'd1 + (n - first) / per;
                  countdown = 16'(per - (n - first) % per);
                  base      = 64'(slot_ticks) * mult;
                  delta     = expiries * 64'(adjust);
                  if (drift == DIR_FASTER) begin
                     period = (base + delta > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : base + delta;
                  end else begin
                     period = (base > delta) ? base - delta : 64'd0;
                  end
                  applied           = applied + delta[15:0];
                  res.period_update = 1'b1;
                  res.slot_period   = period[31:0];
               end
            end
         end
         default: begin
         end
      endcase
      res.clock_direction = drift;
      res.interval_slots  = interval;
      return res;
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result %h with nothing expected", got));
         return;
      end
      want = expected_results.pop_front();
      if (got.period_update !== want.period_update) begin
         report_mismatch($sformatf("period_update %h, expected %h",
                                   got.period_update, want.period_update));
      end
      if (got.slot_period !== want.slot_period) begin
         report_mismatch($sformatf("slot_period %0d, expected %0d",
                                   got.slot_period, want.slot_period));
      end
      if (got.clock_direction !== want.clock_direction) begin
         report_mismatch($sformatf("clock_direction %0d, expected %0d",
                                   got.clock_direction, want.clock_direction));
      end
      if (got.interval_slots !== want.interval_slots) begin
         report_mismatch($sformatf("interval_slots %0d, expected %0d",
                                   got.interval_slots, want.interval_slots));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         slot_ticks = RST_SLOT_DURATION;
         corr_limit = RST_LARGE_LIMIT;
         adjust     = RST_ADJUST;
         clear_drift();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLOT_DURATION: slot_ticks = csr_wdata;
               CSR_LARGE_LIMIT:   corr_limit = csr_wdata[14:0];
               CSR_ADJUST:        adjust     = csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(compensate(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
      end
      outstanding <= expected_results.size();
      failures    <= errs;
   end

endmodule

/* verif/tb_slot_drift_compensator.sv */
// Testbench top: stimulus, flow control and verdict for the slot drift compensator.
module tb_slot_drift_compensator;
   import sdc_pkg::*;

   localparam int          IDLE_LIMIT = 2000;
   localparam logic [63:0] SRC_A      = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] SRC_ONES   = '1;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SLOT_DURATION;
   logic [15:0] csr_wdata = '0;
   int          failures;
   int          outstanding;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   logic [14:0] limit_now = RST_LARGE_LIMIT;
   logic [63:0] cur_src = '0;
   logic [39:0] cur_slot = '0;

   slot_drift_compensator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sdc_drift_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      return calm ? 0 : $urandom_range(9, 0);
   endfunction

   task automatic send_req(input req_type item);
      int gap;
      gap = pick_gap();
      if ($urandom_range(39, 0) == 0) begin
         calm = !calm;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic set_config(input logic [15:0] slot, input logic [14:0] limit,
                             input logic [7:0] adj);
      write_csr(CSR_SLOT_DURATION, slot);
      write_csr(CSR_LARGE_LIMIT, 16'(limit));
      write_csr(CSR_ADJUST, 16'(adj));
      csr_valid <= 1'b0;
      limit_now = limit;
   endtask

   function automatic req_type make_req(input cmd_type cmd, input logic [15:0] corr,
                                        input logic ack, input logic [63:0] src,
                                        input logic synced, input logic [39:0] slot,
                                        input logic [15:0] cnt);
      req_type r;
      r.command         = cmd;
      r.time_correction = corr;
      r.sync_by_ack     = ack;
      r.source_address  = src;
      r.is_synced       = synced;
      r.slot_number     = slot;
      r.slot_count      = cnt;
      return r;
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r.command         = 2'($urandom_range(3, 0));
      r.time_correction = 16'($urandom);
      r.sync_by_ack     = 1'($urandom);
      r.source_address  = {$urandom, $urandom};
      r.is_synced       = 1'($urandom);
      r.slot_number     = 40'({$urandom, $urandom});
      r.slot_count      = 16'($urandom);
      return r;
   endfunction

   function automatic logic [15:0] pick_corr(input bit big);
      int m;
      if (big) begin
         if ($urandom_range(9, 0) < 7) begin
            m = int'(limit_now) + $urandom_range(64, 1);
         end else begin
            m = $urandom_range(32768, int'(limit_now) + 1);
         end
         if (m > 32768) begin
            m = 32768;
         end
      end else begin
         m = $urandom_range(int'(limit_now), 0);
      end
      return $urandom_range(1, 0) ? 16'(m) : 16'(-m);
   endfunction

   function automatic logic [39:0] slot_step();
      if ($urandom_range(32, 0) == 0) begin
         return 40'({$urandom, $urandom});
      end
      return 40'($urandom_range(300, 1));
   endfunction

   task automatic random_item();
      req_type it;
      int      k;
      int      pick;
      it = noise_req();
      k  = $urandom_range(99, 0);
      if (k < 8) begin
         it.command = CMD_SYNC;
         if ($urandom_range(1, 0) == 1) begin
            it.source_address = cur_src;
         end
      end else if (k < 12) begin
         pick = $urandom_range(2, 0);
         it.command        = CMD_SYNC;
         it.is_synced      = 1'b1;
         it.source_address = (pick == 0) ? SRC_A : (pick == 1) ? SRC_ONES : 64'd0;
         it.slot_number    = cur_slot + slot_step();
      end else if (k < 28) begin
         it.command         = CMD_SYNC;
         it.is_synced       = 1'b1;
         it.source_address  = cur_src;
         it.slot_number     = cur_slot + slot_step();
         it.time_correction = pick_corr(1'($urandom_range(1, 0)));
      end else if (k < 30) begin
         it.command = CMD_NOP;
      end else if (k < 46) begin
         it.command = CMD_MULTI;
         if ($urandom_range(4, 0) != 0) begin
            it.slot_count = 16'($urandom_range(60, 0));
         end
      end else begin
         it.command = CMD_TICK;
      end
      if (it.command == CMD_SYNC) begin
         cur_src  = it.source_address;
         cur_slot = it.slot_number;
      end
      send_req(it);
      if ($urandom_range(49, 0) == 0) begin
         wait_for_results();
      end
   endtask

   task automatic run_phase(input int count);
      repeat (count) random_item();
   endtask

   // receiver: random stall before each result, none while calm
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("slot_drift_compensator test failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_req(make_req(CMD_TICK, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd0));
      send_req(make_req(CMD_NOP, 16'hFFFF, 1'b1, SRC_ONES, 1'b1, '1, 16'hFFFF));
      send_req(make_req(CMD_SYNC, 16'd0, 1'b0, SRC_A, 1'b1, 40'd100, 16'd0));
      // small corrections accumulate, wrap and come back to zero
      send_req(make_req(CMD_SYNC, 16'd3, 1'b0, SRC_A, 1'b1, 40'd150, 16'd0));
      send_req(make_req(CMD_SYNC, 16'(-5), 1'b0, SRC_A, 1'b1, 40'd160, 16'd0));
      send_req(make_req(CMD_SYNC, 16'd2, 1'b0, SRC_A, 1'b1, 40'd170, 16'd0));
      send_req(make_req(CMD_SYNC, 16'd20, 1'b0, SRC_A, 1'b1, 40'd1100, 16'd0));
      send_req(make_req(CMD_TICK, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd0));
      send_req(make_req(CMD_MULTI, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd48));
      send_req(make_req(CMD_TICK, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd0));
      send_req(make_req(CMD_MULTI, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd0));
      send_req(make_req(CMD_MULTI, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd200));
      send_req(make_req(CMD_SYNC, 16'd20, 1'b0, SRC_A, 1'b0, 40'd1200, 16'd0));
      // slot number wraps, zero interval
      send_req(make_req(CMD_SYNC, 16'h7FFF, 1'b0, SRC_ONES, 1'b1, 40'hFF_FFFF_FFF0, 16'd0));
      send_req(make_req(CMD_SYNC, 16'h8000, 1'b0, SRC_ONES, 1'b1, 40'h10, 16'd0));
      send_req(make_req(CMD_MULTI, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'hFFFF));
      send_req(make_req(CMD_TICK, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'd0));
      send_req(make_req(CMD_SYNC, 16'd9, 1'b1, SRC_ONES, 1'b1, 40'd106, 16'd0));
      // ack syncs choose the inverse direction
      send_req(make_req(CMD_SYNC, 16'd0, 1'b0, 64'd0, 1'b1, 40'd5, 16'd0));
      send_req(make_req(CMD_SYNC, 16'd9, 1'b1, 64'd0, 1'b1, 40'd95, 16'd0));
      send_req(make_req(CMD_SYNC, 16'd0, 1'b0, 64'd0, 1'b0, 40'd95, 16'd0));
      send_req(make_req(CMD_SYNC, 16'(-100), 1'b1, 64'd0, 1'b1, 40'd1095, 16'd0));
      send_req(make_req(CMD_MULTI, 16'd0, 1'b0, 64'd0, 1'b0, 40'd0, 16'hFFFF));
      send_req(make_req(CMD_SYNC, 16'd8, 1'b0, 64'd0, 1'b1, 40'd2000, 16'd0));
      send_req(make_req(CMD_SYNC, 16'(-9), 1'b0, 64'd0, 1'b1, 40'd2100, 16'd0));
      cur_src  = 64'd0;
      cur_slot = 40'd2100;

      run_phase(100);
      wait_for_results();
      set_config(16'd65535, 15'd0, 8'd255);
      run_phase(120);
      wait_for_results();
      set_config(16'd1, 15'd32767, 8'd1);
      run_phase(100);
      wait_for_results();
      set_config(16'($urandom_range(65535, 1)), 15'($urandom_range(300, 0)),
                 8'($urandom_range(255, 1)));
      run_phase(150);
      wait_for_results();
      set_config(16'd3, 15'd5, 8'd200);
      run_phase(130);
      wait_for_results();
      repeat (60) @(posedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("slot_drift_compensator test passed");
      end else begin
         $display("slot_drift_compensator test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/sdc_pkg.sv
src/sdc_front.sv
src/sdc_queue.sv
src/sdc_div.sv
src/sdc_back.sv
src/slot_drift_compensator.sv
src/sdc_checker.sv
verif/sdc_drift_checker.sv
verif/tb_slot_drift_compensator.sv
